[design/dol_sat_pkg.sv]
// ----------------------------------------------------------------------------
// dol_sat_pkg
// Shared types and constants for the section address translator.
// ----------------------------------------------------------------------------
package dol_sat_pkg;

  // Field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ACT_W   = 2;

  // Header store geometry
  localparam int unsigned HDR_DEPTH = 64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_XLATE  = 2'd2;

  // Slot layout: 7 text slots then 11 data slots. The data tables
  // (0x1C, 0x64, 0xAC) sit right after the text tables, so slot s maps
  // to word base + s for all 18 slots.
  localparam int unsigned TEXT_SLOTS = 7;
  localparam int unsigned DATA_SLOTS = 11;
  localparam int unsigned ALL_SLOTS  = TEXT_SLOTS + DATA_SLOTS;
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(ALL_SLOTS - 1);

  localparam logic [IDX_W-1:0] OFF_WORD   = IDX_W'(32'h00 / 4);
  localparam logic [IDX_W-1:0] LOAD_WORD  = IDX_W'(32'h48 / 4);
  localparam logic [IDX_W-1:0] SIZE_WORD  = IDX_W'(32'h90 / 4);
  localparam logic [IDX_W-1:0] BSSA_WORD  = IDX_W'(32'hD8 / 4);
  localparam logic [IDX_W-1:0] BSSL_WORD  = IDX_W'(32'hDC / 4);
  localparam logic [IDX_W-1:0] ENTRY_WORD = IDX_W'(32'hE0 / 4);

  // Full header length in bytes
  localparam int unsigned HDR_BYTES = 32'h100;

  // Capture select for header read data
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_OFF,
    CAP_LOAD,
    CAP_ENTRY,
    CAP_BSSA,
    CAP_BSSL
  } cap_e;

  // Controller -> datapath
  typedef struct packed {
    logic             hdr_wr;
    logic             hdr_rd;
    logic [IDX_W-1:0] hdr_addr;
    cap_e             cap;
    logic             res_zero;
    logic             clr_count;
    logic             keep_try;
    logic             res_fin;
    logic             map_rd;
    logic [CNT_W-1:0] map_idx;
    logic             hit_cap;
    logic             latch_addr;
    logic             push;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] kept_count;
    logic             match;
    logic             out_busy;
  } status_t;

endpackage

[design/dol_sat_ctrl.sv]
// ----------------------------------------------------------------------------
// dol_sat_ctrl
// Sequencer: header loads, section map build, translate scan, result hand-off.
// ----------------------------------------------------------------------------
module dol_sat_ctrl #(
  parameter int unsigned HEADER_WORDS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dol_sat_pkg::ACT_W-1:0]   action_i,
  input  dol_sat_pkg::status_t            status_i,
  output dol_sat_pkg::cmd_t               cmd_o
);
  import dol_sat_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_FIN_SLOT = 3'd1;
  localparam logic [2:0] ST_FIN_HDR  = 3'd2;
  localparam logic [2:0] ST_TRANS    = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  // Header too short to hold the full layout: finish returns all zeros
  localparam bit ShortHdr = (HEADER_WORDS * 4) < HDR_BYTES;

  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             chk_q, chk_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    slot_d     = slot_q;
    k_d        = k_q;
    chk_d      = chk_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.cap  = CAP_NONE;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (action_i)
            ACT_LOAD: begin
              cmd_o.hdr_wr = 1'b1;
            end
            ACT_FINISH: begin
              cmd_o.res_zero = 1'b1;
              if (ShortHdr) begin
                state_d = ST_DONE;
              end else begin
                cmd_o.clr_count = 1'b1;
                slot_d  = '0;
                phase_d = '0;
                state_d = ST_FIN_SLOT;
              end
            end
            ACT_XLATE: begin
              cmd_o.res_zero   = 1'b1;
              cmd_o.latch_addr = 1'b1;
              k_d     = '0;
              chk_d   = 1'b0;
              state_d = ST_TRANS;
            end
            default: ;
          endcase
        end
      end

      ST_FIN_SLOT: begin
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: begin
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = OFF_WORD + {1'b0, slot_q};
          end
          2'd1: begin
            cmd_o.cap      = CAP_OFF;
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = LOAD_WORD + {1'b0, slot_q};
          end
          2'd2: begin
            cmd_o.cap      = CAP_LOAD;
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = SIZE_WORD + {1'b0, slot_q};
          end
          default: begin
            // size word is on the read port now
            cmd_o.keep_try = 1'b1;
            if (slot_q == LAST_SLOT) begin
              state_d = ST_FIN_HDR;
            end else begin
              slot_d = slot_q + CNT_W'(1);
            end
          end
        endcase
      end

      ST_FIN_HDR: begin
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: begin
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = ENTRY_WORD;
          end
          2'd1: begin
            cmd_o.cap      = CAP_ENTRY;
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = BSSA_WORD;
          end
          2'd2: begin
            cmd_o.cap      = CAP_BSSA;
            cmd_o.hdr_rd   = 1'b1;
            cmd_o.hdr_addr = BSSL_WORD;
          end
          default: begin
            cmd_o.cap     = CAP_BSSL;
            cmd_o.res_fin = 1'b1;
            state_d       = ST_DONE;
          end
        endcase
      end

      ST_TRANS: begin
        // one map read issued per cycle, compared in the next cycle
        priority if (chk_q && status_i.match) begin
          cmd_o.hit_cap = 1'b1;
          chk_d   = 1'b0;
          state_d = ST_DONE;
        end else if (k_q < status_i.kept_count) begin
          cmd_o.map_rd  = 1'b1;
          cmd_o.map_idx = k_q;
          k_d   = k_q + CNT_W'(1);
          chk_d = 1'b1;
        end else begin
          chk_d   = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= '0;
      slot_q  <= '0;
      k_q     <= '0;
      chk_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      slot_q  <= slot_d;
      k_q     <= k_d;
      chk_q   <= chk_d;
    end
  end

endmodule

[design/dol_sat_datapath.sv]
// ----------------------------------------------------------------------------
// dol_sat_datapath
// Header store, section map store, range compare and result registers.
// ----------------------------------------------------------------------------
module dol_sat_datapath #(
  parameter int unsigned MAX_SECTIONS = 18,
  parameter int unsigned HEADER_WORDS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dol_sat_pkg::IDX_W-1:0]    word_index_i,
  input  logic [dol_sat_pkg::WORD_W-1:0]   word_value_i,
  input  logic [dol_sat_pkg::WORD_W-1:0]   address_i,
  input  dol_sat_pkg::cmd_t                cmd_i,
  output dol_sat_pkg::status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   img_offset_o,
  output logic                             parse_ok_o,
  output logic [dol_sat_pkg::CNT_W-1:0]    sect_total_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   start_pc_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   bss_address_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   bss_length_o
);
  import dol_sat_pkg::*;

  localparam int unsigned MapAw = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  // Map entry: range [lo, hi) and offset delta (file offset - load)
  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] delta;
  } map_ent_t;

  // ---- header store, zero until written ----
  logic [WORD_W-1:0]    hdr_mem [HDR_DEPTH];
  logic [HDR_DEPTH-1:0] hv_q;
  logic [WORD_W-1:0]    hdr_rd_q;
  logic                 hdr_rv_q;
  logic [WORD_W-1:0]    hdr_data;
  logic                 idx_ok;

  assign idx_ok   = {1'b0, word_index_i} < (IDX_W + 1)'(HEADER_WORDS);
  assign hdr_data = hdr_rv_q ? hdr_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr && idx_ok) begin
      hdr_mem[word_index_i] <= word_value_i;
    end
    if (cmd_i.hdr_rd) begin
      hdr_rd_q <= hdr_mem[cmd_i.hdr_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q     <= '0;
      hdr_rv_q <= 1'b0;
    end else begin
      if (cmd_i.hdr_wr && idx_ok) begin
        hv_q[word_index_i] <= 1'b1;
      end
      if (cmd_i.hdr_rd) begin
        hdr_rv_q <= hv_q[cmd_i.hdr_addr];
      end
    end
  end

  // ---- map build ----
  logic [WORD_W-1:0] off_q, load_q;
  logic [CNT_W-1:0]  count_q;
  logic              keep;
  map_ent_t          map_mem [MAX_SECTIONS];
  map_ent_t          map_q;
  map_ent_t          wr_ent;

  // hdr_data holds the size word when keep_try is issued
  assign keep = cmd_i.keep_try && (hdr_data != '0) &&
                (count_q < CNT_W'(MAX_SECTIONS));

  always_comb begin
    wr_ent.lo    = load_q;
    wr_ent.hi    = load_q + hdr_data;
    wr_ent.delta = off_q - load_q;
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      map_mem[count_q[MapAw-1:0]] <= wr_ent;
    end
    if (cmd_i.map_rd) begin
      map_q <= map_mem[cmd_i.map_idx[MapAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clr_count) begin
      count_q <= '0;
    end else if (keep) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // ---- translate compare ----
  logic [WORD_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_addr) begin
      addr_q <= address_i;
    end
  end

  assign status_o.kept_count = count_q;
  assign status_o.match      = (addr_q >= map_q.lo) && (addr_q < map_q.hi);
  assign status_o.out_busy   = out_valid_o && !out_ready_i;

  // ---- working result ----
  logic              res_hit_q, res_ok_q;
  logic [WORD_W-1:0] res_off_q, res_entry_q, res_bssa_q, res_bssl_q;
  logic [CNT_W-1:0]  res_cnt_q;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cap)
      CAP_NONE:  ;
      CAP_OFF:   off_q       <= hdr_data;
      CAP_LOAD:  load_q      <= hdr_data;
      CAP_ENTRY: res_entry_q <= hdr_data;
      CAP_BSSA:  res_bssa_q  <= hdr_data;
      CAP_BSSL:  res_bssl_q  <= hdr_data;
      default:   ;
    endcase
    if (cmd_i.res_zero) begin
      res_hit_q   <= 1'b0;
      res_off_q   <= '0;
      res_ok_q    <= 1'b0;
      res_cnt_q   <= '0;
      res_entry_q <= '0;
      res_bssa_q  <= '0;
      res_bssl_q  <= '0;
    end
    if (cmd_i.res_fin) begin
      res_ok_q  <= (count_q != '0);
      res_cnt_q <= count_q;
    end
    if (cmd_i.hit_cap) begin
      res_hit_q <= 1'b1;
      res_off_q <= addr_q + map_q.delta;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hit_o         <= res_hit_q;
      img_offset_o  <= res_off_q;
      parse_ok_o    <= res_ok_q;
      sect_total_o  <= res_cnt_q;
      start_pc_o    <= res_entry_q;
      bss_address_o <= res_bssa_q;
      bss_length_o  <= res_bssl_q;
    end
  end

endmodule

[design/dol_section_address_translator_unit.sv]
// ----------------------------------------------------------------------------
// dol_section_address_translator_unit
// Executable header section map builder and load-address to file-offset
// translator.
// ----------------------------------------------------------------------------
// Usage: write the 256-byte header as big-endian words (action 0, one cycle
// each, indexes at or beyond HEADER_WORDS are dropped), then issue a finish
// (action 1) to build the section map, then issue translates (action 2).
// One transaction is worked on at a time; in_ready_o is high only while the
// sequencer is idle. A finish walks all 18 slots through the single read
// port of the header store, with three reads plus the keep decision per
// slot, then reads entry and bss words. With HEADER_WORDS below 64 a
// finish returns an all-zero result and leaves the map alone. A translate
// scans the kept sections in order through the map store, one entry per
// cycle from a registered map read, and stops early on a hit. While the
// previous result still sits unaccepted in the output register, the new
// result is held back from being posted.
// A result waits in the output register while the next transaction is
// accepted. The header store clears by valid bits at reset, no sweep.
// ----------------------------------------------------------------------------
module dol_section_address_translator_unit #(
  parameter int unsigned MAX_SECTIONS = 18,
  parameter int unsigned HEADER_WORDS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dol_sat_pkg::ACT_W-1:0]    action_i,
  input  logic [dol_sat_pkg::IDX_W-1:0]    word_index_i,
  input  logic [dol_sat_pkg::WORD_W-1:0]   word_value_i,
  input  logic [dol_sat_pkg::WORD_W-1:0]   address_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   img_offset_o,
  output logic                             parse_ok_o,
  output logic [dol_sat_pkg::CNT_W-1:0]    sect_total_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   start_pc_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   bss_address_o,
  output logic [dol_sat_pkg::WORD_W-1:0]   bss_length_o
);
  import dol_sat_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: decodes the transaction, steps slot/phase and scan counters
  dol_sat_ctrl #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Storage, range compare, offset math and output register
  dol_sat_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .HEADER_WORDS (HEADER_WORDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_index_i  (word_index_i),
    .word_value_i  (word_value_i),
    .address_i     (address_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .img_offset_o  (img_offset_o),
    .parse_ok_o    (parse_ok_o),
    .sect_total_o  (sect_total_o),
    .start_pc_o    (start_pc_o),
    .bss_address_o (bss_address_o),
    .bss_length_o  (bss_length_o)
  );

endmodule
